// ===== rtl/mpw_pkg.sv =====
// ----------------------------------------------------------------------------
// mpw_pkg
// Shared types, constants and helper functions of the 2-D max pooling block.
// ----------------------------------------------------------------------------
package mpw_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int MAX_WINDOW  = 8;
  localparam int PIX_W       = 16;
  localparam int POS_W       = 8;
  localparam int CNT_W       = 9;
  localparam int KS_W        = 4;
  localparam int PROD_W      = 13;
  localparam int DIV_STEPS   = 9;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_COLS;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int OQ_DEPTH    = 2;
  localparam int PADDR_W     = 4;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;
  localparam logic [1:0] REG_COLS   = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW = 4'd0;

  typedef struct packed {
    logic [KS_W-1:0]  k;
    logic [KS_W-1:0]  s;
    logic [CNT_W-1:0] nrows;
    logic [CNT_W-1:0] ncols;
  } cfg_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pix;
    logic [POS_W-1:0]        r;
    logic [POS_W-1:0]        c;
    logic [CNT_W-1:0]        rq;
    logic [CNT_W-1:0]        cq;
    logic [CNT_W-1:0]        nr;
    logic [CNT_W-1:0]        nc;
  } mid_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pooled;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [KS_W:0]    rem;
    logic [CNT_W-1:0] quo;
  } div_lane_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN
  } back_state_t;

  // One restoring division step: the next dividend bit enters the remainder.
  function automatic div_lane_t div_step(div_lane_t l, logic [KS_W-1:0] d);
    logic [KS_W:0] rs;
    div_lane_t     o;
    rs    = {l.rem[KS_W-1:0], l.quo[CNT_W-1]};
    o.quo = {l.quo[CNT_W-2:0], 1'b0};
    o.rem = rs;
    if (rs >= {1'b0, d}) begin
      o.rem    = rs - {1'b0, d};
      o.quo[0] = 1'b1;
    end
    return o;
  endfunction

  // Number of windows along one side, given a = ceil((n-k)/s).
  function automatic logic [CNT_W-1:0] win_count(logic [CNT_W-1:0] n,
                                                 logic [KS_W-1:0] k,
                                                 logic [KS_W-1:0] s,
                                                 logic [CNT_W-1:0] a);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(s);
    if (n <= CNT_W'(k)) begin
      return CNT_W'(1);
    end else if (prod >= PROD_W'(n)) begin
      return a;
    end else begin
      return a + CNT_W'(1);
    end
  endfunction

endpackage

// ===== rtl/mpw_ram.sv =====
// ----------------------------------------------------------------------------
// mpw_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mpw_front.sv =====
// ----------------------------------------------------------------------------
// mpw_front
// Accepts pixels, tracks the raster position and divides the position and
// plane sizes by the step to classify each pixel for the back end.
// ----------------------------------------------------------------------------
module mpw_front
  import mpw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    push,
  input  logic signed [PIX_W-1:0] pix,
  output logic                    full,
  input  logic                    q_full,
  output logic                    q_push,
  output mid_item_t               q_item
);

  front_state_t     state_r, state_nxt;
  logic [POS_W-1:0] rpos_r, rpos_nxt;
  logic [POS_W-1:0] cpos_r, cpos_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  mid_item_t        item_r, item_nxt;
  div_lane_t        lanes_r [4];
  div_lane_t        lanes_nxt [4];

  logic             accept;
  logic [CNT_W-1:0] r0, c0, r1, c1;

  assign accept = push && !full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (push) state_nxt = F_DIV;
      F_DIV:  if (cnt_r == 4'(DIV_STEPS - 1)) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state_r != F_IDLE);
    q_push = (state_r == F_PUSH) && !q_full;
  end

  always_comb begin
    q_item    = item_r;
    q_item.rq = lanes_r[0].quo;
    q_item.cq = lanes_r[1].quo;
    q_item.nr = win_count(cfg.nrows, cfg.k, cfg.s, lanes_r[2].quo);
    q_item.nc = win_count(cfg.ncols, cfg.k, cfg.s, lanes_r[3].quo);
  end

  always_comb begin
    r0 = CNT_W'(rpos_r);
    c0 = CNT_W'(cpos_r);
    if (c0 >= cfg.ncols) begin
      c0 = '0;
      r0 = r0 + CNT_W'(1);
    end
    if (r0 >= cfg.nrows) r0 = '0;
    c1 = c0 + CNT_W'(1);
    r1 = r0;
    if (c1 >= cfg.ncols) begin
      c1 = '0;
      r1 = r0 + CNT_W'(1);
      if (r1 >= cfg.nrows) r1 = '0;
    end
  end

  always_comb begin
    rpos_nxt  = rpos_r;
    cpos_nxt  = cpos_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    lanes_nxt = lanes_r;
    if (accept) begin
      rpos_nxt        = r1[POS_W-1:0];
      cpos_nxt        = c1[POS_W-1:0];
      cnt_nxt         = '0;
      item_nxt        = '0;
      item_nxt.pix    = pix;
      item_nxt.r      = r0[POS_W-1:0];
      item_nxt.c      = c0[POS_W-1:0];
      lanes_nxt[0]    = '{rem: '0, quo: r0};
      lanes_nxt[1]    = '{rem: '0, quo: c0};
      lanes_nxt[2]    = '{rem: '0,
                          quo: cfg.nrows - CNT_W'(cfg.k) + CNT_W'(cfg.s) - CNT_W'(1)};
      lanes_nxt[3]    = '{rem: '0,
                          quo: cfg.ncols - CNT_W'(cfg.k) + CNT_W'(cfg.s) - CNT_W'(1)};
    end else if (state_r == F_DIV) begin
      cnt_nxt = cnt_r + 4'd1;
      for (int l = 0; l < 4; l++) begin
        lanes_nxt[l] = div_step(lanes_r[l], cfg.s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      rpos_r  <= '0;
      cpos_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rpos_r  <= rpos_nxt;
      cpos_r  <= cpos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    lanes_r <= lanes_nxt;
  end

endmodule

// ===== rtl/mpw_queue.sv =====
// ----------------------------------------------------------------------------
// mpw_queue
// Two-entry queue of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module mpw_queue
  import mpw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mid_item_t item_in,
  output logic      full,
  input  logic      pop,
  output mid_item_t item_out,
  output logic      empty
);

  mid_item_t  ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign item_out = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
    end
    if (pop && !empty) begin
      rp_nxt = ~rp_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= item_in;
    end
  end

endmodule

// ===== rtl/mpw_back.sv =====
// ----------------------------------------------------------------------------
// mpw_back
// Walks the windows that cover one pixel, updates the running maxima in the
// partial maximum store and queues a result when a window completes.
// ----------------------------------------------------------------------------
module mpw_back
  import mpw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    q_empty,
  input  mid_item_t               q_item,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic signed [PIX_W-1:0] pooled_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    last_of_plane
);

  back_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic              last_step;
  logic              run;

  logic [CNT_W-1:0]  p, q;
  logic [PROD_W-1:0] ps, qs, plim, qlim, er, ec;
  logic              act, start, wend, wlast;
  logic [ADDR_W-1:0] raddr;

  logic                    b_act_r, b_start_r, b_end_r, b_last_r;
  logic [ADDR_W-1:0]       b_idx_r;
  logic [POS_W-1:0]        b_p_r, b_q_r;
  logic signed [PIX_W-1:0] b_pix_r;
  logic [PIX_W-1:0]        rdata;
  logic signed [PIX_W-1:0] cur;

  out_item_t  oq_r [OQ_DEPTH];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       o_push, o_pop;

  assign run       = (state_r == B_RUN);
  assign last_step = ({1'b0, i_r} == cfg.k - 4'd1) && ({1'b0, j_r} == cfg.k - 4'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty && (ocnt_r < 2'(OQ_DEPTH))) state_nxt = B_RUN;
      B_RUN:   if (last_step) state_nxt = B_DRAIN;
      B_DRAIN: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = run && last_step;
    i_nxt = i_r;
    j_nxt = j_r;
    if (!run) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if ({1'b0, j_r} == cfg.k - 4'd1) begin
      j_nxt = '0;
      i_nxt = i_r + SLOT_W'(1);
    end else begin
      j_nxt = j_r + SLOT_W'(1);
    end
  end

  always_comb begin
    p     = q_item.rq - CNT_W'(i_r);
    q     = q_item.cq - CNT_W'(j_r);
    ps    = PROD_W'(p) * PROD_W'(cfg.s);
    qs    = PROD_W'(q) * PROD_W'(cfg.s);
    plim  = ps + PROD_W'(cfg.k);
    qlim  = qs + PROD_W'(cfg.k);
    er    = ((plim < PROD_W'(cfg.nrows)) ? plim : PROD_W'(cfg.nrows)) - PROD_W'(1);
    ec    = ((qlim < PROD_W'(cfg.ncols)) ? qlim : PROD_W'(cfg.ncols)) - PROD_W'(1);
    act   = run
            && (CNT_W'(i_r) <= q_item.rq) && (plim > PROD_W'(q_item.r)) && (p < q_item.nr)
            && (CNT_W'(j_r) <= q_item.cq) && (qlim > PROD_W'(q_item.c)) && (q < q_item.nc);
    start = (ps == PROD_W'(q_item.r)) && (qs == PROD_W'(q_item.c));
    wend  = (er == PROD_W'(q_item.r)) && (ec == PROD_W'(q_item.c));
    wlast = (p == q_item.nr - CNT_W'(1)) && (q == q_item.nc - CNT_W'(1));
    raddr = {p[SLOT_W-1:0], q[COL_W-1:0]};
  end

  mpw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (b_act_r),
    .waddr (b_idx_r),
    .wdata (cur),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cur = b_pix_r;
    if (!b_start_r && ($signed(rdata) > b_pix_r)) begin
      cur = $signed(rdata);
    end
  end

  assign o_push        = b_act_r && b_end_r;
  assign o_pop         = pop && !empty;
  assign empty         = (ocnt_r == 2'd0);
  assign pooled_value  = oq_r[orp_r].pooled;
  assign out_row       = oq_r[orp_r].row;
  assign out_col       = oq_r[orp_r].col;
  assign last_of_plane = oq_r[orp_r].last;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (o_push && !o_pop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (!o_push && o_pop) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      b_act_r <= 1'b0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      b_act_r <= act;
      ocnt_r  <= ocnt_nxt;
      if (o_push) owp_r <= ~owp_r;
      if (o_pop) orp_r <= ~orp_r;
    end
  end

  always_ff @(posedge clk) begin
    b_start_r <= start;
    b_end_r   <= wend;
    b_last_r  <= wlast;
    b_idx_r   <= raddr;
    b_p_r     <= p[POS_W-1:0];
    b_q_r     <= q[POS_W-1:0];
    b_pix_r   <= q_item.pix;
    if (o_push) begin
      oq_r[owp_r] <= '{pooled: cur, row: b_p_r, col: b_q_r, last: b_last_r};
    end
  end

endmodule

// ===== rtl/max_pool_2d_window.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_window
// Streaming 2-D max pooling in ceil mode over raster-ordered Q8.8 planes.
//
//   Channel   Ports                              Handshake
//   input     in_pixel_value                     push / full
//   result    out_pooled_value, out_row,         pop / empty
//             out_col, out_last_of_plane
//   config    paddr, pwdata, prdata              psel / penable / pready
//
// The front end handles a transaction in steps: accept, nine steps of the
// four divider lanes by the step size, and hand-off to the queue.
// The back end does one store read-modify-write per candidate window of a
// pixel, while the queue lets the front end work on the next pixel.
// Reset is synchronous; the partial maximum store is not cleared.
// A full result queue stalls the back end, which in turn stalls the front.
// ----------------------------------------------------------------------------
module max_pool_2d_window
  import mpw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [PIX_W-1:0] in_pixel_value,
  input  logic                    pop,
  output logic                    empty,
  output logic signed [PIX_W-1:0] out_pooled_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    out_last_of_plane,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [KS_W-1:0]  win_r, step_r;
  logic [CNT_W-1:0] rows_r, cols_r;
  cfg_t             cfg;
  logic             wr_en;

  logic      mq_push, mq_full, mq_pop, mq_empty;
  mid_item_t mq_in, mq_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= 4'd2;
      step_r <= 4'd2;
      rows_r <= 9'd256;
      cols_r <= 9'd256;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WINDOW: win_r  <= pwdata[KS_W-1:0];
        REG_STEP:   step_r <= pwdata[KS_W-1:0];
        REG_ROWS:   rows_r <= pwdata[CNT_W-1:0];
        REG_COLS:   cols_r <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = 32'(win_r);
      REG_STEP:   prdata = 32'(step_r);
      REG_ROWS:   prdata = 32'(rows_r);
      REG_COLS:   prdata = 32'(cols_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.k = win_r;
    if (win_r == '0) cfg.k = KS_W'(1);
    else if (win_r > KS_W'(MAX_WINDOW)) cfg.k = KS_W'(MAX_WINDOW);
    cfg.s = (step_r == '0) ? KS_W'(1) : step_r;
    cfg.nrows = rows_r;
    if (rows_r == '0) cfg.nrows = CNT_W'(1);
    else if (rows_r > CNT_W'(MAX_ROWS)) cfg.nrows = CNT_W'(MAX_ROWS);
    cfg.ncols = cols_r;
    if (cols_r == '0) cfg.ncols = CNT_W'(1);
    else if (cols_r > CNT_W'(MAX_COLS)) cfg.ncols = CNT_W'(MAX_COLS);
  end

  mpw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .push   (push),
    .pix    (in_pixel_value),
    .full   (full),
    .q_full (mq_full),
    .q_push (mq_push),
    .q_item (mq_in)
  );

  mpw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mq_push),
    .item_in  (mq_in),
    .full     (mq_full),
    .pop      (mq_pop),
    .item_out (mq_out),
    .empty    (mq_empty)
  );

  mpw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (mq_empty),
    .q_item        (mq_out),
    .q_pop         (mq_pop),
    .pop           (pop),
    .empty         (empty),
    .pooled_value  (out_pooled_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_plane (out_last_of_plane)
  );

endmodule

// ===== rtl/mpw_checker.sv =====
// ----------------------------------------------------------------------------
// mpw_checker
// Port-level checks of the max pooling block, bound to the top level.
// ----------------------------------------------------------------------------
module mpw_port_props
  import mpw_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    push,
  input logic                    full,
  input logic signed [PIX_W-1:0] in_pixel_value,
  input logic                    pop,
  input logic                    empty,
  input logic signed [PIX_W-1:0] out_pooled_value,
  input logic [POS_W-1:0]        out_row,
  input logic [POS_W-1:0]        out_col,
  input logic                    out_last_of_plane,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [PADDR_W-1:0]      paddr,
  input logic [31:0]             pwdata,
  input logic [31:0]             prdata,
  input logic                    pready
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side not ready after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pooled_value) && $stable(out_row)
                          && $stable(out_col) && $stable(out_last_of_plane)))
    else $error("waiting result changed before pop");

  a_window_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr == ADDR_WINDOW)
      ##1 (psel && !pwrite && paddr == ADDR_WINDOW)
      |-> prdata[KS_W-1:0] == $past(pwdata[KS_W-1:0]))
    else $error("window size register did not read back");

endmodule

bind max_pool_2d_window mpw_port_props u_mpw_port_props (.*);
